>>> rtl/core/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants, codes, command/status structs and sequence helpers for
// the go-back-n link controller.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int WINDOW_SIZE    = 4;
  localparam int SEQ_MAX        = 7;
  localparam int PAYLOAD_BYTES  = 256;
  localparam int SEQ_MOD        = SEQ_MAX + 1;
  localparam int FRAME_OVERHEAD = 7;
  localparam int MIN_FRAME_LEN  = 5;

  localparam int OP_W   = 2;
  localparam int SEQ_W  = 3;
  localparam int SLOT_W = 2;
  localparam int LEN_W  = 9;
  localparam int ACT_W  = 3;
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_NET_READY  = 2'd0,
    OP_PHYS_READY = 2'd1,
    OP_FRAME      = 2'd2,
    OP_TIMEOUT    = 2'd3
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_SEND    = 3'd0,
    ACT_ACK     = 3'd1,
    ACT_DELIVER = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_GATE    = 3'd4
  } action_t;

  typedef struct packed {
    logic    latch_in;
    logic    set_phys;
    logic    start_resend;
    logic    emit;
    logic    from_resend;
    action_t sel;
  } dp_cmd_t;

  typedef struct packed {
    op_t              op;
    logic             frame_good;
    logic             is_ack;
    logic             seq_match;
    logic             window_free;
    logic             window_empty;
    logic             release_ok;
    logic             resend_last;
    logic             out_free;
    logic [CNT_W-1:0] frames_buffered;
  } dp_status_t;

  function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
    return (s == SEQ_W'(SEQ_MAX)) ? '0 : s + SEQ_W'(1);
  endfunction

  function automatic logic [SEQ_W-1:0] seq_prev(input logic [SEQ_W-1:0] s);
    return (s == '0) ? SEQ_W'(SEQ_MAX) : s - SEQ_W'(1);
  endfunction

  // b lies in the circular interval [a, c)
  function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                     input logic [SEQ_W-1:0] b,
                                     input logic [SEQ_W-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

endpackage

>>> rtl/core/gbn_datapath.sv
// ----------------------------------------------------------------------------
// gbn_datapath
// Window pointers, buffered-frame count, latched event and result register.
// ----------------------------------------------------------------------------
module gbn_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [gbn_pkg::OP_W-1:0]    op,
  input  logic                        rx_kind,
  input  logic [gbn_pkg::SEQ_W-1:0]   rx_seq,
  input  logic [gbn_pkg::SEQ_W-1:0]   rx_ack,
  input  logic [gbn_pkg::LEN_W-1:0]   rx_length,
  input  logic                        rx_crc_ok,
  input  gbn_pkg::dp_cmd_t            cmd,
  output gbn_pkg::dp_status_t         status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gbn_pkg::ACT_W-1:0]   action,
  output logic [gbn_pkg::SEQ_W-1:0]   frame_seq,
  output logic [gbn_pkg::SEQ_W-1:0]   ack_number,
  output logic [gbn_pkg::SLOT_W-1:0]  buffer_slot,
  output logic [gbn_pkg::LEN_W-1:0]   deliver_length,
  output logic                        network_enable,
  output logic                        last
);
  import gbn_pkg::*;

  // latched event
  op_t              op_q;
  logic             kind_q;
  logic [SEQ_W-1:0] seq_q;
  logic [SEQ_W-1:0] ack_q;
  logic [LEN_W-1:0] len_q;
  logic             crc_q;

  // link state
  logic [SEQ_W-1:0] oldest_unacked;
  logic [SEQ_W-1:0] next_to_send;
  logic [SEQ_W-1:0] expected_rx_seq;
  logic [CNT_W-1:0] frames_buffered;
  logic             physical_ready;

  // resend walk
  logic [SEQ_W-1:0] resend_seq;
  logic [CNT_W-1:0] resend_left;

  logic [LEN_W-1:0]  dlen;
  logic [ACT_W-1:0]  action_next;
  logic [SEQ_W-1:0]  frame_seq_next;
  logic [SEQ_W-1:0]  ack_number_next;
  logic [SLOT_W-1:0] buffer_slot_next;
  logic [LEN_W-1:0]  deliver_length_next;
  logic              network_enable_next;
  logic              window_free;

  assign window_free = frames_buffered < CNT_W'(WINDOW_SIZE);

  always_comb begin
    if (len_q < LEN_W'(FRAME_OVERHEAD)) begin
      dlen = '0;
    end else begin
      dlen = len_q - LEN_W'(FRAME_OVERHEAD);
    end
    if (dlen > LEN_W'(PAYLOAD_BYTES)) begin
      dlen = LEN_W'(PAYLOAD_BYTES);
    end
  end

  always_comb begin
    action_next         = cmd.sel;
    frame_seq_next      = '0;
    ack_number_next     = '0;
    buffer_slot_next    = '0;
    deliver_length_next = '0;
    network_enable_next = 1'b0;
    case (cmd.sel)
      ACT_SEND: begin
        frame_seq_next   = cmd.from_resend ? resend_seq : next_to_send;
        ack_number_next  = seq_prev(expected_rx_seq);
        buffer_slot_next = SLOT_W'(frame_seq_next % WINDOW_SIZE);
      end
      ACT_ACK: begin
        ack_number_next = seq_prev(expected_rx_seq);
      end
      ACT_DELIVER: begin
        frame_seq_next      = seq_q;
        deliver_length_next = dlen;
      end
      ACT_STOP: begin
        frame_seq_next = oldest_unacked;
      end
      ACT_GATE: begin
        network_enable_next = window_free && physical_ready;
      end
      default: begin
        action_next = ACT_GATE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_q   <= op_t'(op);
      kind_q <= rx_kind;
      seq_q  <= SEQ_W'(rx_seq % SEQ_MOD);
      ack_q  <= SEQ_W'(rx_ack % SEQ_MOD);
      len_q  <= rx_length;
      crc_q  <= rx_crc_ok;
    end
    if (cmd.emit) begin
      action         <= action_next;
      frame_seq      <= frame_seq_next;
      ack_number     <= ack_number_next;
      buffer_slot    <= buffer_slot_next;
      deliver_length <= deliver_length_next;
      network_enable <= network_enable_next;
      last           <= (cmd.sel == ACT_GATE);
    end
    if (cmd.start_resend) begin
      resend_seq <= oldest_unacked;
    end else if (cmd.emit && cmd.sel == ACT_SEND && cmd.from_resend) begin
      resend_seq <= seq_next(resend_seq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_unacked  <= '0;
      next_to_send    <= '0;
      expected_rx_seq <= '0;
      frames_buffered <= '0;
      physical_ready  <= 1'b0;
      resend_left     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.set_phys) begin
        physical_ready <= 1'b1;
      end
      if (cmd.start_resend) begin
        resend_left <= frames_buffered;
      end
      if (cmd.emit) begin
        case (cmd.sel)
          ACT_SEND: begin
            physical_ready <= 1'b0;
            if (cmd.from_resend) begin
              resend_left <= resend_left - CNT_W'(1);
            end else begin
              frames_buffered <= frames_buffered + CNT_W'(1);
              next_to_send    <= seq_next(next_to_send);
            end
          end
          ACT_ACK: begin
            physical_ready <= 1'b0;
          end
          ACT_DELIVER: begin
            expected_rx_seq <= seq_next(expected_rx_seq);
          end
          ACT_STOP: begin
            frames_buffered <= frames_buffered - CNT_W'(1);
            oldest_unacked  <= seq_next(oldest_unacked);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    status.op              = op_q;
    status.frame_good      = (len_q >= LEN_W'(MIN_FRAME_LEN)) && crc_q;
    status.is_ack          = (kind_q == KIND_ACK);
    status.seq_match       = (seq_q == expected_rx_seq);
    status.window_free     = window_free;
    status.window_empty    = (frames_buffered == '0);
    status.release_ok      = (frames_buffered != '0) &&
                             in_window(oldest_unacked, ack_q, next_to_send);
    status.resend_last     = (resend_left == CNT_W'(1));
    status.out_free        = !out_valid || !out_stall;
    status.frames_buffered = frames_buffered;
  end

endmodule

>>> rtl/core/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer walking one event through its commands, at most one result a cycle into a free result register.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gbn_pkg::dp_status_t status,
  output gbn_pkg::dp_cmd_t    cmd
);
  import gbn_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_SEND    = 8'b0000_0100,
    S_DELIVER = 8'b0000_1000,
    S_ACK     = 8'b0001_0000,
    S_RELEASE = 8'b0010_0000,
    S_RESEND  = 8'b0100_0000,
    S_GATE    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    cmd.latch_in     = 1'b0;
    cmd.set_phys     = 1'b0;
    cmd.start_resend = 1'b0;
    cmd.emit         = 1'b0;
    cmd.from_resend  = 1'b0;
    cmd.sel          = ACT_GATE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.op)
          OP_NET_READY: begin
            state_next = status.window_free ? S_SEND : S_GATE;
          end
          OP_PHYS_READY: begin
            cmd.set_phys = 1'b1;
            state_next   = S_GATE;
          end
          OP_FRAME: begin
            if (!status.frame_good) begin
              state_next = S_GATE;
            end else if (status.is_ack) begin
              state_next = S_RELEASE;
            end else begin
              state_next = status.seq_match ? S_DELIVER : S_ACK;
            end
          end
          OP_TIMEOUT: begin
            if (status.window_empty) begin
              state_next = S_GATE;
            end else begin
              cmd.start_resend = 1'b1;
              state_next       = S_RESEND;
            end
          end
          default: begin
            state_next = S_GATE;
          end
        endcase
      end
      S_SEND: begin
        cmd.sel = ACT_SEND;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_GATE;
        end
      end
      S_DELIVER: begin
        cmd.sel = ACT_DELIVER;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_ACK;
        end
      end
      S_ACK: begin
        cmd.sel = ACT_ACK;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_RELEASE;
        end
      end
      S_RELEASE: begin
        // one stop-timer per acked frame until the ack falls outside the window
        cmd.sel = ACT_STOP;
        if (!status.release_ok) begin
          state_next = S_GATE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      S_RESEND: begin
        cmd.sel         = ACT_SEND;
        cmd.from_resend = 1'b1;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.resend_last) begin
            state_next = S_GATE;
          end
        end
      end
      S_GATE: begin
        cmd.sel = ACT_GATE;
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/go_back_n_link_controller.sv
// ----------------------------------------------------------------------------
// go_back_n_link_controller
// Go-back-n sliding window link controller: turns link events into send,
// ack, deliver, stop-timer and network gate commands.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  event in | in_valid / in_stall  | op rx_kind rx_seq rx_ack rx_length rx_crc_ok
//  cmd out  | out_valid / out_stall| action frame_seq ack_number buffer_slot
//           |                      | deliver_length network_enable last
//
//  an event is accepted, then decoded, then walked through its command states;
//  the ack release walk ends in a check that emits nothing, the gate ends each
//  event, and at most one command a cycle goes through the single result register
//  a timeout resends the buffered frames one per cycle, oldest unacked first, but
//  out_stall holds the sequencer; in_stall stays high until the gate is loaded
//  synchronous reset clears window pointers, frame count and physical-ready
// ----------------------------------------------------------------------------
module go_back_n_link_controller (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gbn_pkg::OP_W-1:0]    op,
  input  logic                        rx_kind,
  input  logic [gbn_pkg::SEQ_W-1:0]   rx_seq,
  input  logic [gbn_pkg::SEQ_W-1:0]   rx_ack,
  input  logic [gbn_pkg::LEN_W-1:0]   rx_length,
  input  logic                        rx_crc_ok,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gbn_pkg::ACT_W-1:0]   action,
  output logic [gbn_pkg::SEQ_W-1:0]   frame_seq,
  output logic [gbn_pkg::SEQ_W-1:0]   ack_number,
  output logic [gbn_pkg::SLOT_W-1:0]  buffer_slot,
  output logic [gbn_pkg::LEN_W-1:0]   deliver_length,
  output logic                        network_enable,
  output logic                        last
);
  import gbn_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gbn_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .rx_kind        (rx_kind),
    .rx_seq         (rx_seq),
    .rx_ack         (rx_ack),
    .rx_length      (rx_length),
    .rx_crc_ok      (rx_crc_ok),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .action         (action),
    .frame_seq      (frame_seq),
    .ack_number     (ack_number),
    .buffer_slot    (buffer_slot),
    .deliver_length (deliver_length),
    .network_enable (network_enable),
    .last           (last)
  );

  // window never overflows
  assert property (@(posedge clk) disable iff (rst)
    status.frames_buffered <= CNT_W'(WINDOW_SIZE))
    else $error("frame count beyond window");

  // an accepted event blocks the input until its gate is loaded
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an event is in flight");

  // last marks the gate and only the gate
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (action == ACT_GATE)))
    else $error("last flag does not match gate result");

  // a new command is only loaded over a free result register
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

endmodule
